[hdl/kfef_pkg.sv]
// ----------------------------------------------------------------------------
// kfef_pkg
// Shared types, codes and key tables for the keyword field extract filter.
// ----------------------------------------------------------------------------
package kfef_pkg;

    // Length of the search key "intentStr":" including its quotes.
    localparam int KEY_LEN = 13;

    // Byte constants used by the filter.
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Register indexes as decoded from paddr[2].
    localparam logic REG_OUTPUT_LIMIT    = 1'b0;
    localparam logic REG_WHOLE_TEXT_MODE = 1'b1;

    // Reset value of the output limit register.
    localparam logic [6:0] OUTPUT_LIMIT_RESET = 7'd64;

    // Phase of the text scan.
    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_COLLECT,
        PH_DONE,
        PH_FILTER
    } kfef_phase_t;

    // Delivery request from the scanner to the store sequencer.
    typedef struct packed {
        logic start;
        logic term;
        logic not_found;
    } kfef_req_t;

    // Byte of the key at a given match position.
    function automatic logic [7:0] key_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h22;
            4'd1:    b = 8'h69;
            4'd2:    b = 8'h6E;
            4'd3:    b = 8'h74;
            4'd4:    b = 8'h65;
            4'd5:    b = 8'h6E;
            4'd6:    b = 8'h74;
            4'd7:    b = 8'h53;
            4'd8:    b = 8'h74;
            4'd9:    b = 8'h72;
            4'd10:   b = 8'h22;
            4'd11:   b = 8'h3A;
            4'd12:   b = 8'h22;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Advance the key matcher by one byte. The prefix table only ever falls
    // back to position one or zero, so at most two fallback steps are needed.
    function automatic logic [3:0] match_step(input logic [3:0] pos,
                                              input logic [7:0] b);
        logic [3:0] res;
        logic       fb_one;
        fb_one = (pos == 4'd11);
        if (key_byte(pos) == b) begin
            res = pos + 4'd1;
        end else if (pos == 4'd0) begin
            res = 4'd0;
        end else if (fb_one && (key_byte(4'd1) == b)) begin
            res = 4'd2;
        end else if (key_byte(4'd0) == b) begin
            res = 4'd1;
        end else begin
            res = 4'd0;
        end
        return res;
    endfunction

endpackage

[hdl/keyword_field_extract_filter.sv]
// ----------------------------------------------------------------------------
// keyword_field_extract_filter
// Extracts the quoted field after the key "intentStr":" from a byte stream,
// or filters the whole text, dropping digits and carriage returns.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_in_byte, s_end_of_text
//  m_        out        m_valid/m_ready    m_out_byte, m_last_item, m_status
//  APB       in         psel/penable       paddr, pwdata, prdata
//
// The scanner accepts one item per cycle while s_ready is high.
// A delivery of k result items holds s_ready low while the sequencer
// loads them through the store's read port, one item per cycle except
// while m_ready stays low. Reset needs no clearing pass: the
// keyword store is only read at entries written during the current text.
// ----------------------------------------------------------------------------
module keyword_field_extract_filter #(
    parameter int MAX_KEYWORD = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_item,
    output logic        m_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W  = $clog2(MAX_KEYWORD + 1);
    localparam int ADDR_W = (MAX_KEYWORD > 1) ? $clog2(MAX_KEYWORD) : 1;

    logic [6:0]          output_limit_reg;
    logic                whole_text_mode_reg;
    logic                busy, accept, wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [7:0]          wr_data;
    kfef_pkg::kfef_req_t req;
    logic [CNT_W-1:0]    req_count;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_limit_reg    <= kfef_pkg::OUTPUT_LIMIT_RESET;
            whole_text_mode_reg <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                kfef_pkg::REG_OUTPUT_LIMIT:    output_limit_reg    <= pwdata[6:0];
                kfef_pkg::REG_WHOLE_TEXT_MODE: whole_text_mode_reg <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Configuration register reads.
    always_comb begin
        unique case (paddr[2])
            kfef_pkg::REG_OUTPUT_LIMIT:    prdata = {25'd0, output_limit_reg};
            kfef_pkg::REG_WHOLE_TEXT_MODE: prdata = {31'd0, whole_text_mode_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    assign pready  = 1'b1;
    assign s_ready = !busy;
    assign accept  = s_valid && s_ready;

    // Scanner and matcher.
    kfef_scan #(
        .MAX_KEYWORD (MAX_KEYWORD),
        .CNT_W       (CNT_W),
        .ADDR_W      (ADDR_W)
    ) u_scan (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .in_byte         (s_in_byte),
        .end_of_text     (s_end_of_text),
        .output_limit    (output_limit_reg),
        .whole_text_mode (whole_text_mode_reg),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .req             (req),
        .req_count       (req_count)
    );

    // Keyword store and delivery.
    kfef_store #(
        .MAX_KEYWORD (MAX_KEYWORD),
        .CNT_W       (CNT_W),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .req         (req),
        .req_count   (req_count),
        .busy        (busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_item (m_last_item),
        .m_status    (m_status)
    );

endmodule

[hdl/kfef_scan.sv]
// ----------------------------------------------------------------------------
// kfef_scan
// Text scanner: key matcher, phase control, kept-byte counter and store
// write port; raises a delivery request at the closing quote or text end.
// ----------------------------------------------------------------------------
module kfef_scan #(
    parameter int MAX_KEYWORD = 64,
    parameter int CNT_W       = $clog2(MAX_KEYWORD + 1),
    parameter int ADDR_W      = (MAX_KEYWORD > 1) ? $clog2(MAX_KEYWORD) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [7:0]         in_byte,
    input  logic               end_of_text,
    input  logic [6:0]         output_limit,
    input  logic               whole_text_mode,
    output logic               wr_en,
    output logic [ADDR_W-1:0]  wr_addr,
    output logic [7:0]         wr_data,
    output kfef_pkg::kfef_req_t req,
    output logic [CNT_W-1:0]   req_count
);

    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEYWORD);

    kfef_pkg::kfef_phase_t phase_reg, phase_next, phase_mid, phase_eff;
    logic [3:0]       match_reg, match_next, match_eff, match_adv;
    logic [CNT_W-1:0] kept_reg, kept_next, kept_mid;

    logic             nonzero, is_end, is_quote, keepable, has_room, store_it;
    logic [CMP_W-1:0] limit_ext, lim_wide;
    logic [CNT_W-1:0] lim;
    logic             term, deliver, not_found;

    // Byte classification.
    always_comb begin
        nonzero  = (in_byte != 8'h00);
        is_end   = end_of_text || !nonzero;
        is_quote = (in_byte == kfef_pkg::CHAR_QUOTE);
        keepable = !((in_byte >= kfef_pkg::CHAR_ZERO) && (in_byte <= kfef_pkg::CHAR_NINE))
                   && (in_byte != kfef_pkg::CHAR_CR);
        has_room = (kept_reg < MAX_CNT);
    end

    // Whole-text mode takes over while still searching; the partial match
    // is dropped in that case.
    always_comb begin
        if ((phase_reg == kfef_pkg::PH_SEARCH) && whole_text_mode) begin
            phase_eff = kfef_pkg::PH_FILTER;
            match_eff = 4'd0;
        end else begin
            phase_eff = phase_reg;
            match_eff = match_reg;
        end
        match_adv = kfef_pkg::match_step(match_eff, in_byte);
    end

    // Next state: effect of the byte, then the return to reset at text end.
    always_comb begin
        phase_mid = phase_eff;
        kept_mid  = kept_reg;
        match_next = match_eff;
        unique case (phase_eff)
            kfef_pkg::PH_SEARCH: begin
                if (nonzero) begin
                    if (match_adv == 4'(kfef_pkg::KEY_LEN)) begin
                        phase_mid  = kfef_pkg::PH_COLLECT;
                        match_next = 4'd0;
                    end else begin
                        match_next = match_adv;
                    end
                end
            end
            kfef_pkg::PH_COLLECT: begin
                if (nonzero && is_quote) begin
                    phase_mid = kfef_pkg::PH_DONE;
                end else if (nonzero && keepable && has_room) begin
                    kept_mid = kept_reg + CNT_W'(1);
                end
            end
            kfef_pkg::PH_FILTER: begin
                if (nonzero && keepable && has_room) begin
                    kept_mid = kept_reg + CNT_W'(1);
                end
            end
            kfef_pkg::PH_DONE: begin
            end
            default: begin
            end
        endcase

        phase_next = phase_mid;
        kept_next  = kept_mid;
        if (is_end) begin
            phase_next = kfef_pkg::PH_SEARCH;
            match_next = 4'd0;
            kept_next  = '0;
        end
    end

    // Outputs: store write and delivery request.
    always_comb begin
        store_it = nonzero && keepable && has_room &&
                   (((phase_eff == kfef_pkg::PH_COLLECT) && !is_quote) ||
                    (phase_eff == kfef_pkg::PH_FILTER));
        wr_en   = accept && store_it;
        wr_addr = kept_reg[ADDR_W-1:0];
        wr_data = in_byte;

        // Limit clamped to 1..MAX_KEYWORD.
        limit_ext = CMP_W'(output_limit);
        if (output_limit == 7'd0) begin
            lim_wide = CMP_W'(1);
        end else if (limit_ext > CMP_W'(MAX_KEYWORD)) begin
            lim_wide = CMP_W'(MAX_KEYWORD);
        end else begin
            lim_wide = limit_ext;
        end
        lim = lim_wide[CNT_W-1:0];

        deliver   = accept &&
                    (((phase_eff == kfef_pkg::PH_COLLECT) && nonzero && is_quote) ||
                     (is_end && (phase_mid == kfef_pkg::PH_FILTER)));
        not_found = accept && is_end &&
                    ((phase_mid == kfef_pkg::PH_SEARCH) ||
                     (phase_mid == kfef_pkg::PH_COLLECT));
        term      = (kept_mid < lim);

        req.start     = deliver || not_found;
        req.not_found = not_found;
        req.term      = not_found || term;
        if (not_found) begin
            req_count = '0;
        end else if (term) begin
            req_count = kept_mid;
        end else begin
            req_count = lim;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= kfef_pkg::PH_SEARCH;
            match_reg <= 4'd0;
            kept_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            match_reg <= match_next;
            kept_reg  <= kept_next;
        end
    end

endmodule

[hdl/kfef_store.sv]
// ----------------------------------------------------------------------------
// kfef_store
// Keyword store memory with its delivery sequencer and output register.
// ----------------------------------------------------------------------------
module kfef_store #(
    parameter int MAX_KEYWORD = 64,
    parameter int CNT_W       = $clog2(MAX_KEYWORD + 1),
    parameter int ADDR_W      = (MAX_KEYWORD > 1) ? $clog2(MAX_KEYWORD) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [7:0]          wr_data,
    input  kfef_pkg::kfef_req_t req,
    input  logic [CNT_W-1:0]    req_count,
    output logic                busy,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_last_item,
    output logic                m_status
);

    logic [7:0] mem [MAX_KEYWORD];

    logic             seq_active_reg;
    logic [CNT_W-1:0] idx_reg, data_cnt_reg, total_reg;
    logic             nf_reg;

    logic             valid_reg, last_reg, status_reg, is_data_reg;
    logic [7:0]       rdata_reg;

    logic             advance, issue, issue_last;

    // An item is loaded whenever the output register is empty or draining.
    always_comb begin
        advance    = !valid_reg || m_ready;
        issue      = seq_active_reg && advance;
        issue_last = (idx_reg == (total_reg - CNT_W'(1)));
    end

    // Store write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Store read port; the read register doubles as the output payload.
    always_ff @(posedge aclk) begin
        if (issue) begin
            rdata_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    // Sequencer: one item per cycle unless stalled; keyword bytes, any terminator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_active_reg <= 1'b0;
            idx_reg        <= '0;
        end else if (req.start) begin
            seq_active_reg <= 1'b1;
            idx_reg        <= '0;
        end else if (issue) begin
            idx_reg <= idx_reg + CNT_W'(1);
            if (issue_last) begin
                seq_active_reg <= 1'b0;
            end
        end
    end

    // Request parameters.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            data_cnt_reg <= req_count;
            total_reg    <= req_count + CNT_W'(req.term);
            nf_reg       <= req.not_found;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            last_reg    <= issue_last;
            status_reg  <= nf_reg;
            is_data_reg <= (idx_reg < data_cnt_reg);
        end
    end

    assign busy        = seq_active_reg;
    assign m_valid     = valid_reg;
    assign m_out_byte  = is_data_reg ? rdata_reg : 8'h00;
    assign m_last_item = last_reg;
    assign m_status    = status_reg;

endmodule
